>>> hw/rtl/oscts_pkg.sv
// Shared types, character codes and prefix-match helper for the OSC title extractor.
// No dependencies; imported by oscts_step and osc_title_sequence_extractor.
package oscts_pkg;

	localparam logic [7:0] CH_ESC     = 8'h1b;
	localparam logic [7:0] CH_BEL     = 8'h07;
	localparam logic [7:0] CH_BRACKET = 8'h5d;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_TWO     = 8'h32;
	localparam logic [7:0] CH_SEMI    = 8'h3b;
	localparam logic [7:0] CH_BSLASH  = 8'h5c;
	localparam logic [7:0] PRINT_LO   = 8'd32;
	localparam logic [7:0] PRINT_HI   = 8'd126;

	localparam logic [7:0] TITLE_LIMIT_RESET = 8'd200;

	localparam int unsigned PADDR_W = 3;
	localparam logic REG_ENABLE = 1'b0;
	localparam logic REG_LIMIT  = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_ESC   = 3'd1,
		PH_BR    = 3'd2,
		PH_NUM   = 3'd3,
		PH_TITLE = 3'd4,
		PH_TESC  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_OK   = 2'd1,
		KIND_DROP = 2'd2
	} kind_t;

	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [7:0] title_byte;
		logic [7:0] byte_index;
		logic [7:0] title_length;
	} result_t;

	// Advance the ESC ] 0|2 ; prefix matcher by one byte.
	function automatic phase_t match_next(input phase_t ph, input logic [7:0] b);
		phase_t nph;
		nph = PH_IDLE;
		if (b == CH_ESC) begin
			nph = PH_ESC;
		end else begin
			case (ph)
				PH_ESC: nph = (b == CH_BRACKET) ? PH_BR : PH_IDLE;
				PH_BR:  nph = (b == CH_ZERO || b == CH_TWO) ? PH_NUM : PH_IDLE;
				PH_NUM: nph = (b == CH_SEMI) ? PH_TITLE : PH_IDLE;
				default: nph = PH_IDLE;
			endcase
		end
		return nph;
	endfunction

endpackage

>>> hw/rtl/oscts_step.sv
// Per-byte next-state and result logic of the OSC title extractor.
// Depends on oscts_pkg (phase codes, characters, match_next, result_t).
module oscts_step import oscts_pkg::*; (
	input  logic       enable,
	input  logic [7:0] title_limit,
	input  phase_t     phase,
	input  logic [7:0] title_count,
	input  logic [7:0] data_byte,
	input  logic       end_of_buffer,
	output phase_t     phase_next,
	output logic [7:0] count_next,
	output result_t    result
);

	logic   is_bel, is_esc, is_bsl, is_prn, below;
	logic   tesc_end, title_mode;
	phase_t ph_mid;

	assign is_bel = (data_byte == CH_BEL);
	assign is_esc = (data_byte == CH_ESC);
	assign is_bsl = (data_byte == CH_BSLASH);
	assign is_prn = (data_byte >= PRINT_LO) && (data_byte <= PRINT_HI);
	assign below  = (title_count < title_limit);

	// ESC backslash closes the title
	assign tesc_end   = (phase == PH_TESC) && is_bsl;
	// byte is handled as a title byte: in title, or a held ESC past the limit
	assign title_mode = (phase == PH_TITLE) || ((phase == PH_TESC) && !is_bsl && !below);

	// next state
	always_comb begin
		ph_mid     = PH_IDLE;
		count_next = title_count;
		case (phase)
			PH_TITLE, PH_TESC: begin
				if (tesc_end) begin
					ph_mid = PH_IDLE;
				end else if (!title_mode) begin
					ph_mid = match_next(PH_ESC, data_byte);
				end else if (is_bel) begin
					ph_mid = PH_IDLE;
				end else if (is_esc) begin
					ph_mid = PH_TESC;
				end else if (below) begin
					ph_mid = is_prn ? PH_TITLE : PH_IDLE;
					if (is_prn) begin
						count_next = title_count + 8'd1;
					end
				end else begin
					ph_mid = PH_TITLE;
				end
			end
			PH_ESC, PH_BR, PH_NUM: begin
				ph_mid = match_next(phase, data_byte);
				if (ph_mid == PH_TITLE) begin
					count_next = '0;
				end
			end
			default: ph_mid = match_next(PH_IDLE, data_byte);
		endcase
		if (!enable) begin
			ph_mid     = PH_IDLE;
			count_next = title_count;
		end
		phase_next = end_of_buffer ? PH_IDLE : ph_mid;
	end

	// result
	always_comb begin
		result      = '0;
		result.kind = KIND_DROP;
		if (enable) begin
			if (tesc_end || (title_mode && is_bel)) begin
				result.valid = 1'b1;
				if (title_count != 8'd0) begin
					result.kind         = KIND_OK;
					result.title_length = title_count;
				end
			end else if ((phase == PH_TESC) && below) begin
				result.valid = 1'b1;
			end else if (title_mode && !is_esc && below) begin
				result.valid = 1'b1;
				if (is_prn) begin
					result.kind       = KIND_BYTE;
					result.title_byte = data_byte;
					result.byte_index = title_count;
				end
			end
			// end of buffer drops a title still open
			if (end_of_buffer && (ph_mid == PH_TITLE || ph_mid == PH_TESC)) begin
				result              = '0;
				result.valid        = 1'b1;
				result.kind         = KIND_DROP;
			end
		end
	end

endmodule

>>> hw/rtl/osc_title_sequence_extractor.sv
// Top level of the OSC window-title extractor: request registers, APB config, output stage.
// Depends on oscts_pkg and oscts_step.
//
// Path: an accepted request passes the input register, then the result register, before
// it appears on the result port; requests that give no result leave nothing.
// Throughput: one request per cycle unless result_stall holds a result in stage 2.
// Reset (arst_n low, asynchronous): detection off, limit 200, matcher idle, stages empty.
module osc_title_sequence_extractor import oscts_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// APB configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// byte request channel
	input  logic               byte_valid,
	output logic               byte_stall,
	input  logic [7:0]         data_byte,
	input  logic               end_of_buffer,
	// result channel
	output logic               result_valid,
	input  logic               result_stall,
	output logic [1:0]         kind,
	output logic [7:0]         title_byte,
	output logic [7:0]         byte_index,
	output logic [7:0]         title_length
);

	logic       enable_q;
	logic [7:0] title_limit_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eob_s1;

	phase_t     phase_q;
	logic [7:0] count_q;

	phase_t     phase_next;
	logic [7:0] count_next;
	result_t    step_res;

	logic       valid_s2;
	result_t    res_s2;

	logic       out_blocked;
	logic       advance;
	logic       cfg_wr;

	// APB: zero wait states, registers decoded by the word address bit
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b0;
			title_limit_q <= TITLE_LIMIT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_ENABLE: enable_q      <= pwdata[0];
				REG_LIMIT:  title_limit_q <= pwdata[7:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ENABLE: prdata = {31'd0, enable_q};
			REG_LIMIT:  prdata = {24'd0, title_limit_q};
			default:    prdata = '0;
		endcase
	end

	// The stage-1 request moves on unless a result sits stalled in stage 2.
	assign out_blocked = valid_s2 && result_stall;
	assign advance     = valid_s1 && !out_blocked;
	// Hold the input only while stage 1 is full and cannot drain.
	assign byte_stall  = valid_s1 && out_blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			byte_s1 <= data_byte;
			eob_s1  <= end_of_buffer;
		end
	end

	oscts_step u_step (
		.enable        (enable_q),
		.title_limit   (title_limit_q),
		.phase         (phase_q),
		.title_count   (count_q),
		.data_byte     (byte_s1),
		.end_of_buffer (eob_s1),
		.phase_next    (phase_next),
		.count_next    (count_next),
		.result        (step_res)
	);

	// Matcher state advances once per processed request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
		end else if (advance) begin
			phase_q <= phase_next;
			count_q <= count_next;
		end
	end

	// Result register: load on advance, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= step_res.valid;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= step_res;
		end
	end

	assign result_valid = valid_s2;
	assign kind         = res_s2.kind;
	assign title_byte   = res_s2.title_byte;
	assign byte_index   = res_s2.byte_index;
	assign title_length = res_s2.title_length;

endmodule
